>>> hw/rtl/jrsa_pkg.sv
`timescale 1ns / 1ps

package jrsa_pkg;

    // Queue of outstanding entries
    localparam int QUEUE_DEPTH = 64;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Region layout
    localparam int HEADER_REGION   = 4096;
    localparam int ENTRY_HDR_BYTES = 32;
    localparam int PAGE_BITS       = 12;

    // Field and datapath widths
    localparam int POS_W   = 41;
    localparam int SEQ_W   = 64;
    localparam int LEN_W   = 32;
    localparam int ALIGN_W = 13;
    localparam int ALOG_W  = 5;
    localparam int FPAD_W  = 12;
    localparam int BPAD_W  = 16;
    localparam int DROP_W  = 7;
    localparam int SIZE_W  = 35;
    localparam int ROOM_W  = 44;

    // Configuration register indexes
    localparam logic [1:0] CFG_RING_SIZE  = 2'd0;
    localparam logic [1:0] CFG_ALIGN_LOG2 = 2'd1;
    localparam logic [1:0] CFG_STALL_FULL = 2'd2;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_COMMIT = 2'd1,
        ACT_START  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_APPENDED = 2'd0,
        ST_REJECTED = 2'd1,
        ST_APPLIED  = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_NOT_FULL = 2'd0,
        MODE_FULL     = 2'd1,
        MODE_WAIT     = 2'd2
    } mode_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic size;
        logic decide;
        logic wrap;
        logic cmt_begin;
        logic pop;
        logic cmt_finish;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic seq_newer;
        logic pop_ok;
    } dp_sts_t;

    // Result item as held in the output register
    typedef struct packed {
        logic [1:0]        status;
        logic [POS_W-1:0]  entry_pos;
        logic [POS_W-1:0]  entry_size;
        logic [FPAD_W-1:0] front_pad;
        logic [BPAD_W-1:0] back_pad;
        logic              half_crossed;
        logic              header_dirty;
        logic [1:0]        ring_mode;
        logic [POS_W-1:0]  start_pos;
        logic [DROP_W-1:0] dropped;
    } result_t;

endpackage

>>> hw/rtl/jrsa_req_if.sv
`timescale 1ns / 1ps

interface jrsa_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      action;
    logic [jrsa_pkg::SEQ_W-1:0]      seq;
    logic [jrsa_pkg::LEN_W-1:0]      payload_len;
    logic signed [jrsa_pkg::ALIGN_W-1:0] data_align;

    modport source (output valid, action, seq, payload_len, data_align, input ready);
    modport sink   (input valid, action, seq, payload_len, data_align, output ready);
endinterface

>>> hw/rtl/jrsa_rsp_if.sv
`timescale 1ns / 1ps

interface jrsa_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [jrsa_pkg::POS_W-1:0]      entry_pos;
    logic [jrsa_pkg::POS_W-1:0]      entry_size;
    logic [jrsa_pkg::FPAD_W-1:0]     front_pad;
    logic [jrsa_pkg::BPAD_W-1:0]     back_pad;
    logic                            half_crossed;
    logic                            header_dirty;
    logic [1:0]                      ring_mode;
    logic [jrsa_pkg::POS_W-1:0]      start_pos;
    logic [jrsa_pkg::DROP_W-1:0]     dropped;

    modport source (output valid, status, entry_pos, entry_size, front_pad, back_pad,
                    half_crossed, header_dirty, ring_mode, start_pos, dropped,
                    input ready);
    modport sink   (input valid, status, entry_pos, entry_size, front_pad, back_pad,
                    half_crossed, header_dirty, ring_mode, start_pos, dropped,
                    output ready);
endinterface

>>> hw/rtl/jrsa_ctrl.sv
`timescale 1ns / 1ps

module jrsa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_action,
    output logic              out_valid,
    input  logic              out_ready,
    input  jrsa_pkg::dp_sts_t sts,
    output jrsa_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIZE,
        S_DECIDE,
        S_WRAP,
        S_CMT_TEST,
        S_CMT_READ,
        S_CMT_CHECK,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Decode commands for the datapath
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:      cmd.capture    = in_valid;
            S_SIZE:      cmd.size       = 1'b1;
            S_DECIDE:    cmd.decide     = 1'b1;
            S_WRAP:      cmd.wrap       = 1'b1;
            S_CMT_TEST:  cmd.cmt_begin  = sts.seq_newer;
            S_CMT_READ:  cmd.pop        = 1'b0;
            S_CMT_CHECK:
            begin
                cmd.pop        = sts.pop_ok;
                cmd.cmt_finish = !sts.pop_ok;
            end
            S_EMIT:      cmd.emit       = !out_valid_reg || out_ready;
            default:     cmd            = '0;
        endcase
    end

    // Sequence the item and hold the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid on a load, drop it once the result is taken
            if ((state_reg == S_EMIT) && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        unique case (jrsa_pkg::action_t'(in_action))
                            jrsa_pkg::ACT_APPEND: state_reg <= S_SIZE;
                            jrsa_pkg::ACT_COMMIT: state_reg <= S_CMT_TEST;
                            jrsa_pkg::ACT_START:  state_reg <= S_EMIT;
                            jrsa_pkg::ACT_NONE:   state_reg <= S_EMIT;
                            default:              state_reg <= S_EMIT;
                        endcase
                    end
                end
                S_SIZE:     state_reg <= S_DECIDE;
                S_DECIDE:   state_reg <= S_WRAP;
                S_WRAP:     state_reg <= S_EMIT;
                S_CMT_TEST: state_reg <= sts.seq_newer ? S_CMT_READ : S_EMIT;
                S_CMT_READ: state_reg <= S_CMT_CHECK;
                S_CMT_CHECK:
                begin
                    state_reg <= sts.pop_ok ? S_CMT_READ : S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                        state_reg <= S_IDLE;
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/jrsa_datapath.sv
`timescale 1ns / 1ps

module jrsa_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_index,
    input  logic [jrsa_pkg::POS_W-1:0]      cfg_wdata,
    input  logic [1:0]                      in_action,
    input  logic [jrsa_pkg::SEQ_W-1:0]      in_seq,
    input  logic [jrsa_pkg::LEN_W-1:0]      in_len,
    input  logic [jrsa_pkg::ALIGN_W-1:0]    in_align,
    input  jrsa_pkg::cmd_t                  cmd,
    output jrsa_pkg::dp_sts_t               sts,
    output jrsa_pkg::result_t               res
);

    localparam int POS_W  = jrsa_pkg::POS_W;
    localparam int SIZE_W = jrsa_pkg::SIZE_W;
    localparam int ROOM_W = jrsa_pkg::ROOM_W;
    localparam int CNT_W  = jrsa_pkg::CNT_W;
    localparam int QIDX_W = jrsa_pkg::QIDX_W;

    // Configuration and control state
    logic [POS_W-1:0]            ring_size_reg;
    logic [jrsa_pkg::ALOG_W-1:0] align_log2_reg;
    logic                        stall_reg;
    logic [POS_W-1:0]            wr_pos_reg;
    logic [POS_W-1:0]            oldest_reg;
    jrsa_pkg::mode_t             mode_reg;
    logic [jrsa_pkg::SEQ_W-1:0]  last_seq_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [QIDX_W-1:0]           head_reg;

    // Item and working registers
    logic [jrsa_pkg::SEQ_W-1:0]     seq_reg;
    logic [jrsa_pkg::LEN_W-1:0]     len_reg;
    logic [jrsa_pkg::ALIGN_W-1:0]   align_reg;
    jrsa_pkg::status_t              status_reg;
    logic [POS_W-1:0]               epos_reg;
    logic [SIZE_W-1:0]              esize_reg;
    logic [jrsa_pkg::FPAD_W-1:0]    fpad_reg;
    logic [jrsa_pkg::BPAD_W-1:0]    bpad_reg;
    logic                           half_reg;
    logic                           dirty_reg;
    logic [jrsa_pkg::DROP_W-1:0]    dropped_reg;
    logic signed [ROOM_W-1:0]       room_reg;
    logic                           elig_reg;
    logic                           appended_reg;
    logic [POS_W:0]                 np_reg;
    jrsa_pkg::result_t              res_reg;

    // Pending queue storage
    logic [jrsa_pkg::SEQ_W-1:0] q_seq_mem [jrsa_pkg::QUEUE_DEPTH];
    logic [POS_W-1:0]           q_pos_mem [jrsa_pkg::QUEUE_DEPTH];
    logic [jrsa_pkg::SEQ_W-1:0] rd_seq_reg;
    logic [POS_W-1:0]           rd_pos_reg;

    logic [jrsa_pkg::FPAD_W-1:0] fpad_c;
    logic [SIZE_W-1:0]           raw_c;
    logic [SIZE_W-1:0]           gmask_c;
    logic [SIZE_W-1:0]           esize_c;
    logic [SIZE_W-1:0]           bpad_full_c;
    logic signed [ROOM_W-1:0]    room_c;
    logic                        elig_c;
    logic signed [ROOM_W-1:0]    size_s;
    logic signed [ROOM_W-1:0]    half_mark;
    logic                        fits_c;
    logic                        half_c;
    logic [POS_W:0]              np_c;
    logic [POS_W+1:0]            wrap_c;
    logic [POS_W-1:0]            new_wp_c;
    logic [CNT_W:0]              tail_sum;
    logic [QIDX_W-1:0]           tail_idx;
    logic [QIDX_W-1:0]           head_next;
    logic                        mem_we;

    // Entry layout: front pad, rounded size, back pad
    always_comb
    begin
        fpad_c      = align_reg[jrsa_pkg::ALIGN_W-1] ? '0 :
                      (align_reg[jrsa_pkg::FPAD_W-1:0] -
                       jrsa_pkg::FPAD_W'(jrsa_pkg::ENTRY_HDR_BYTES));
        raw_c       = SIZE_W'(2 * jrsa_pkg::ENTRY_HDR_BYTES) + SIZE_W'(len_reg)
                      + SIZE_W'(fpad_c);
        gmask_c     = (SIZE_W'(1) << align_log2_reg) - SIZE_W'(1);
        esize_c     = (raw_c + gmask_c) & ~gmask_c;
        bpad_full_c = (~raw_c + SIZE_W'(1)) & gmask_c;
    end

    // Free room, one byte held back
    always_comb
    begin
        if (wr_pos_reg >= oldest_reg)
            room_c = ROOM_W'(ring_size_reg) - ROOM_W'(wr_pos_reg) + ROOM_W'(oldest_reg)
                     - ROOM_W'(jrsa_pkg::HEADER_REGION) - ROOM_W'(1);
        else
            room_c = ROOM_W'(oldest_reg) - ROOM_W'(wr_pos_reg) - ROOM_W'(1);
        elig_c = (mode_reg == jrsa_pkg::MODE_NOT_FULL) &&
                 (count_reg < CNT_W'(jrsa_pkg::QUEUE_DEPTH));
    end

    // Room check, half mark and next position
    always_comb
    begin
        size_s    = ROOM_W'(esize_reg);
        half_mark = ROOM_W'(ring_size_reg >> 1);
        fits_c    = (room_reg >= size_s);
        half_c    = elig_reg && (room_reg < half_mark) && ((room_reg + size_s) > half_mark);
        np_c      = (POS_W + 1)'(wr_pos_reg) + (POS_W + 1)'(esize_reg);
        wrap_c    = (POS_W + 2)'(np_reg) + (POS_W + 2)'(jrsa_pkg::HEADER_REGION)
                    - (POS_W + 2)'(ring_size_reg);
        new_wp_c  = (np_reg >= (POS_W + 1)'(ring_size_reg)) ? wrap_c[POS_W-1:0]
                                                            : np_reg[POS_W-1:0];
    end

    // Queue indexes
    always_comb
    begin
        tail_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
        if (tail_sum >= (CNT_W + 1)'(jrsa_pkg::QUEUE_DEPTH))
            tail_sum = tail_sum - (CNT_W + 1)'(jrsa_pkg::QUEUE_DEPTH);
        tail_idx = tail_sum[QIDX_W-1:0];
        if ((CNT_W)'(head_reg) == CNT_W'(jrsa_pkg::QUEUE_DEPTH - 1))
            head_next = '0;
        else
            head_next = head_reg + QIDX_W'(1);
        mem_we = cmd.decide && elig_reg && fits_c;
    end

    assign sts.seq_newer = (seq_reg > last_seq_reg);
    assign sts.pop_ok    = (count_reg != '0) && (rd_seq_reg <= seq_reg);
    assign res           = res_reg;

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg  <= POS_W'(1048576);
            align_log2_reg <= jrsa_pkg::ALOG_W'(4);
            stall_reg      <= 1'b0;
            wr_pos_reg     <= POS_W'(jrsa_pkg::HEADER_REGION);
            oldest_reg     <= POS_W'(jrsa_pkg::HEADER_REGION);
            mode_reg       <= jrsa_pkg::MODE_NOT_FULL;
            last_seq_reg   <= '0;
            count_reg      <= '0;
            head_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    jrsa_pkg::CFG_RING_SIZE:  ring_size_reg  <= cfg_wdata;
                    jrsa_pkg::CFG_ALIGN_LOG2: align_log2_reg <= cfg_wdata[jrsa_pkg::ALOG_W-1:0];
                    jrsa_pkg::CFG_STALL_FULL: stall_reg      <= cfg_wdata[0];
                    default:                  stall_reg      <= stall_reg;
                endcase
            end

            // Step the full / wait state on a commit start
            if (cmd.capture && (in_action == jrsa_pkg::ACT_START))
            begin
                if (mode_reg == jrsa_pkg::MODE_FULL)
                    mode_reg <= jrsa_pkg::MODE_WAIT;
                else if (mode_reg == jrsa_pkg::MODE_WAIT)
                    mode_reg <= jrsa_pkg::MODE_NOT_FULL;
            end

            // Queue the entry, or enter full mode unless stall on full is set
            if (cmd.decide && elig_reg)
            begin
                if (fits_c)
                    count_reg <= count_reg + CNT_W'(1);
                else if (!stall_reg)
                    mode_reg <= jrsa_pkg::MODE_FULL;
            end

            // Advance the write position with wraparound
            if (cmd.wrap && appended_reg)
                wr_pos_reg <= new_wp_c;

            if (cmd.cmt_begin)
                last_seq_reg <= seq_reg;

            // Release the head entry
            if (cmd.pop)
            begin
                head_reg  <= head_next;
                count_reg <= count_reg - CNT_W'(1);
            end

            // Move the start of the live region
            if (cmd.cmt_finish)
                oldest_reg <= (count_reg != '0) ? rd_pos_reg : wr_pos_reg;
        end
    end

    // Item fields and result under construction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            seq_reg     <= in_seq;
            len_reg     <= in_len;
            align_reg   <= in_align;
            epos_reg    <= (in_action == jrsa_pkg::ACT_APPEND) ? wr_pos_reg : '0;
            esize_reg   <= '0;
            fpad_reg    <= '0;
            bpad_reg    <= '0;
            half_reg    <= 1'b0;
            dirty_reg   <= 1'b0;
            dropped_reg <= '0;
            status_reg  <= (in_action == jrsa_pkg::ACT_APPEND) ? jrsa_pkg::ST_REJECTED
                                                               : jrsa_pkg::ST_IGNORED;
        end

        if (cmd.size)
        begin
            esize_reg <= esize_c;
            fpad_reg  <= fpad_c;
            bpad_reg  <= bpad_full_c[jrsa_pkg::BPAD_W-1:0];
            room_reg  <= room_c;
            elig_reg  <= elig_c;
        end

        if (cmd.decide)
        begin
            half_reg     <= half_c;
            np_reg       <= np_c;
            appended_reg <= elig_reg && fits_c;
            if (elig_reg && fits_c)
                status_reg <= jrsa_pkg::ST_APPENDED;
        end

        if (cmd.wrap && appended_reg)
            dirty_reg <= (np_reg > (POS_W + 1)'(ring_size_reg));

        if (cmd.cmt_begin)
        begin
            dirty_reg  <= 1'b1;
            status_reg <= jrsa_pkg::ST_APPLIED;
        end

        if (cmd.pop)
            dropped_reg <= dropped_reg + jrsa_pkg::DROP_W'(1);

        // Load the output register
        if (cmd.emit)
        begin
            res_reg.status       <= status_reg;
            res_reg.entry_pos    <= epos_reg;
            res_reg.entry_size   <= POS_W'(esize_reg);
            res_reg.front_pad    <= fpad_reg;
            res_reg.back_pad     <= bpad_reg;
            res_reg.half_crossed <= half_reg;
            res_reg.header_dirty <= dirty_reg;
            res_reg.ring_mode    <= mode_reg;
            res_reg.start_pos    <= oldest_reg;
            res_reg.dropped      <= dropped_reg;
        end
    end

    // Queue memory: one write, one registered read at the head
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            q_seq_mem[tail_idx] <= seq_reg;
            q_pos_mem[tail_idx] <= wr_pos_reg;
        end
        rd_seq_reg <= q_seq_mem[head_reg];
        rd_pos_reg <= q_pos_mem[head_reg];
    end

endmodule

>>> hw/rtl/journal_ring_space_allocator_core.sv
`timescale 1ns / 1ps
// Channel | Dir | Handshake      | Payload
// req     | in  | valid / ready  | action, seq, payload_len, data_align
// rsp     | out | valid / ready  | status, entry_pos, entry_size, front_pad, back_pad,
//         |     |                | half_crossed, header_dirty, ring_mode, start_pos, dropped
// cfg     | in  | cfg_wr_en      | cfg_index, cfg_wdata
//
// One item at a time. An append steps through size, decide and wrap; a commit start
// or unused action goes straight to emit; a stale commit only tests its sequence; an
// applied commit releases entries in turn, each by a registered read of the queue head.
// The result waits in the output register; a stalled rsp holds the block only
// when the next result is ready to be loaded. No clearing pass after reset:
// the pending queue is tracked by head and count only.
module journal_ring_space_allocator_core (
    input  logic                       clk,
    input  logic                       rst_n,
    jrsa_req_if.sink                   req,
    jrsa_rsp_if.source                 rsp,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [jrsa_pkg::POS_W-1:0] cfg_wdata
);

    jrsa_pkg::cmd_t    cmd;
    jrsa_pkg::dp_sts_t sts;
    jrsa_pkg::result_t res;

    jrsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_action (req.action),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    jrsa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_action (req.action),
        .in_seq    (req.seq),
        .in_len    (req.payload_len),
        .in_align  (req.data_align),
        .cmd       (cmd),
        .sts       (sts),
        .res       (res)
    );

    // Drive the result payload
    assign rsp.status       = res.status;
    assign rsp.entry_pos    = res.entry_pos;
    assign rsp.entry_size   = res.entry_size;
    assign rsp.front_pad    = res.front_pad;
    assign rsp.back_pad     = res.back_pad;
    assign rsp.half_crossed = res.half_crossed;
    assign rsp.header_dirty = res.header_dirty;
    assign rsp.ring_mode    = res.ring_mode;
    assign rsp.start_pos    = res.start_pos;
    assign rsp.dropped      = res.dropped;

    // Applied and ignored results carry no entry layout
    a_commit_no_layout : assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == jrsa_pkg::ST_APPLIED || rsp.status == jrsa_pkg::ST_IGNORED)
        |-> (rsp.entry_size == '0) && (rsp.front_pad == '0) && !rsp.half_crossed)
        else $error("commit result carries entry layout");

    // Only an applied commit releases entries
    a_drop_only_commit : assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != jrsa_pkg::ST_APPLIED) |-> (rsp.dropped == '0))
        else $error("entries released outside an applied commit");

    // An appended entry leaves the ring not full
    a_append_mode : assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == jrsa_pkg::ST_APPENDED)
        |-> (rsp.ring_mode == jrsa_pkg::MODE_NOT_FULL))
        else $error("append accepted while ring is full");

    // No queue release or append decision while a new item can be taken
    a_pop_busy : assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !cmd.pop && !cmd.decide)
        else $error("datapath work while input is open");

endmodule

>>> tb/sv/journal_ring_space_allocator_core_tb.sv
`timescale 1ns / 1ps

module journal_ring_space_allocator_core_tb;
    import jrsa_pkg::*;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [12:0] NO_ALIGN     = 13'h1FFF;
    localparam logic [63:0] POS_MASK     = (64'd1 << POS_W) - 64'd1;
    localparam logic [63:0] SEQ_ALL_ONES = '1;

    typedef struct {
        action_t            action;
        logic [SEQ_W-1:0]   seq;
        logic [LEN_W-1:0]   len;
        logic [ALIGN_W-1:0] align;
    } log_req_t;

    typedef struct {
        log_req_t req;
        bit       typed;
        result_t  want;
    } dir_row_t;

    typedef struct {
        logic [63:0] seq;
        logic [63:0] pos;
    } live_entry_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [1:0]           cfg_index;
    logic [POS_W-1:0]     cfg_wdata;

    jrsa_req_if req_ch ();
    jrsa_rsp_if rsp_ch ();

    journal_ring_space_allocator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Mirror of the allocator registers and state
    logic [63:0]  ring_end;
    logic [4:0]   gran_log2;
    logic         stall_mode;
    logic [63:0]  wr_pos;
    logic [63:0]  live_start;
    mode_t        fill_state;
    logic [63:0]  committed_seq;
    live_entry_t  live_entries[$];
    logic [63:0]  fresh_seq;

    result_t      pending_results[$];
    dir_row_t     directed_rows[$];
    int           mismatch_count;
    int           result_count;
    int           cycle_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    logic         hold_armed;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatch_count < 40)
            $display("mismatch on %s at result %0d: got %0d, want %0d",
                     what, result_count, got, want);
        mismatch_count++;
    endtask

    // Compute one item's result and advance the mirrored state
    function automatic result_t allocate_or_commit(input log_req_t it);
        result_t     r;
        logic [63:0] base, gran, fpad, esize, np;
        longint      room, halfmark, sz;
        live_entry_t e;
        int          released;
        r = '0;
        r.status = ST_IGNORED;
        released = 0;
        case (it.action)
            ACT_APPEND:
            begin
                base = 64'(2 * ENTRY_HDR_BYTES) + 64'(it.len);
                gran = 64'd1 << gran_log2;
                fpad = 64'd0;
                if (!it.align[ALIGN_W-1])
                    fpad = (64'(it.align[11:0]) - 64'(ENTRY_HDR_BYTES)) & 64'hFFF;
                esize = (base + fpad + gran - 64'd1) & ~(gran - 64'd1);
                r.entry_pos  = wr_pos[POS_W-1:0];
                r.entry_size = esize[POS_W-1:0];
                r.front_pad  = fpad[FPAD_W-1:0];
                r.back_pad   = 16'(esize - base - fpad);
                r.status     = ST_REJECTED;
                if (fill_state == MODE_NOT_FULL && live_entries.size() < QUEUE_DEPTH)
                begin
                    halfmark = longint'(ring_end) / 2;
                    if (wr_pos >= live_start)
                        room = longint'(ring_end) - longint'(wr_pos)
                             + longint'(live_start) - longint'(HEADER_REGION) - 1;
                    else
                        room = longint'(live_start) - longint'(wr_pos) - 1;
                    sz = longint'(esize);
                    r.half_crossed = (room < halfmark) && (room + sz > halfmark);
                    if (room >= sz)
                    begin
                        np = wr_pos + esize;
                        r.status = ST_APPENDED;
                        r.header_dirty = (np > ring_end);
                        e.seq = it.seq;
                        e.pos = wr_pos;
                        live_entries.insert(live_entries.size(), e);
                        if (np >= ring_end)
                            np = np + 64'(HEADER_REGION) - ring_end;
                        wr_pos = np & POS_MASK;
                    end
                    else if (!stall_mode)
                        fill_state = MODE_FULL;
                end
            end
            ACT_COMMIT:
            begin
                if (it.seq > committed_seq)
                begin
                    committed_seq = it.seq;
                    while (live_entries.size() > 0 && live_entries[0].seq <= it.seq)
                    begin
                        live_entries.delete(0);
                        released++;
                    end
                    live_start = (live_entries.size() > 0) ? live_entries[0].pos : wr_pos;
                    r.header_dirty = 1'b1;
                    r.status = ST_APPLIED;
                end
            end
            ACT_START:
            begin
                if (fill_state == MODE_FULL)
                    fill_state = MODE_WAIT;
                else if (fill_state == MODE_WAIT)
                    fill_state = MODE_NOT_FULL;
            end
            default:
            begin
            end
        endcase
        r.ring_mode = fill_state;
        r.start_pos = live_start[POS_W-1:0];
        r.dropped   = 7'(released);
        return r;
    endfunction

    // Draw a request that mostly follows a live append/commit flow
    function automatic log_req_t pick_log_request(input int commit_pct);
        log_req_t    it;
        int          r, m, a;
        logic [63:0] span, gap;
        bit          doomed;
        r = $urandom_range(0, 99);
        doomed = (fill_state != MODE_NOT_FULL) || (live_entries.size() == QUEUE_DEPTH);
        it.seq   = {$urandom, $urandom};
        it.len   = $urandom;
        it.align = 13'($urandom);
        if (fill_state != MODE_NOT_FULL && r < 35)
            it.action = ACT_START;
        else if (r < commit_pct)
            it.action = ACT_COMMIT;
        else if (r < commit_pct + 6)
            it.action = ACT_START;
        else if (r < commit_pct + 9)
            it.action = ACT_NONE;
        else
            it.action = ACT_APPEND;

        if (it.action == ACT_COMMIT)
        begin
            if ($urandom_range(0, 9) == 0)
                it.seq = committed_seq & {$urandom, $urandom};
            else
            begin
                span = fresh_seq - committed_seq;
                if (span > 64'd40)
                    span = 64'd40;
                it.seq = committed_seq + 64'd1 + 64'($urandom_range(0, 32'(span)));
            end
        end
        else if (it.action == ACT_APPEND)
        begin
            if (!doomed)
            begin
                it.seq = fresh_seq;
                fresh_seq++;
            end
            m = $urandom_range(0, 99);
            a = $urandom_range(0, 99);
            if (a < 25)
                it.align = NO_ALIGN;
            else if (a >= 35)
                it.align = 13'($urandom_range(0, 4095));
            gap = ring_end - wr_pos;
            if (m < 5)
                it.len = $urandom;
            else if (m < 15 && ring_end > wr_pos && gap >= 64'd64
                     && gap - 64'd64 <= 64'hFFFF_FFFF)
            begin
                // Size the unpadded entry to end exactly on the end of the region
                it.len   = 32'(gap - 64'd64);
                it.align = NO_ALIGN;
            end
            else if (m < 30)
                it.len = $urandom_range(0, 65535);
            else
                it.len = $urandom_range(0, 1500);
        end
        return it;
    endfunction

    // Offer one item, wait for acceptance and queue its expectation
    task automatic drive_item(input log_req_t it, input bit typed, input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= it.action;
        req_ch.seq         <= it.seq;
        req_ch.payload_len <= it.len;
        req_ch.data_align  <= it.align;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = allocate_or_commit(it);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    task automatic add_row(input action_t act, input logic [63:0] seq,
                           input logic [31:0] len, input logic [12:0] align,
                           input bit typed, input result_t want);
        dir_row_t row;
        row.req.action = act;
        row.req.seq    = seq;
        row.req.len    = len;
        row.req.align  = align;
        row.typed      = typed;
        row.want       = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    function automatic result_t typed_result(input status_t st, input longint unsigned pos,
                                             input longint unsigned size, input int fpad,
                                             input int bpad, input bit half, input bit dirty,
                                             input mode_t mode, input longint unsigned start,
                                             input int drop);
        result_t r;
        r.status       = st;
        r.entry_pos    = 41'(pos);
        r.entry_size   = 41'(size);
        r.front_pad    = 12'(fpad);
        r.back_pad     = 16'(bpad);
        r.half_crossed = half;
        r.header_dirty = dirty;
        r.ring_mode    = mode;
        r.start_pos    = 41'(start);
        r.dropped      = 7'(drop);
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [POS_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_RING_SIZE:  ring_end   = 64'(val);
            CFG_ALIGN_LOG2: gran_log2  = val[4:0];
            CFG_STALL_FULL: stall_mode = val[0];
            default:
            begin
            end
        endcase
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input logic [POS_W-1:0] ring, input int alog, input bit stall,
                             input int sidle, input int rstall, input int items,
                             input int commit_pct, input bit pressure);
        drain_results();
        write_reg(CFG_RING_SIZE, ring);
        write_reg(CFG_ALIGN_LOG2, 41'(alog));
        write_reg(CFG_STALL_FULL, 41'(stall));
        cfg_wr_en <= 1'b0;
        send_idle_pct = sidle;
        recv_stall_pct <= rstall;
        if (pressure)
            hold_armed <= 1'b1;
        repeat (items)
            drive_item(pick_log_request(commit_pct), 1'b0, '0);
    endtask

    // Receiver: random stalls, plus one long hold-off once armed
    initial
    begin
        int hold_count;
        hold_count   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed && hold_count < HOLD_CYCLES)
            begin
                rsp_ch.ready <= 1'b0;
                hold_count++;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
        begin
            got.status       = rsp_ch.status;
            got.entry_pos    = rsp_ch.entry_pos;
            got.entry_size   = rsp_ch.entry_size;
            got.front_pad    = rsp_ch.front_pad;
            got.back_pad     = rsp_ch.back_pad;
            got.half_crossed = rsp_ch.half_crossed;
            got.header_dirty = rsp_ch.header_dirty;
            got.ring_mode    = rsp_ch.ring_mode;
            got.start_pos    = rsp_ch.start_pos;
            got.dropped      = rsp_ch.dropped;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 64'(got.status), 0);
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.entry_pos !== want.entry_pos)
                    report_mismatch("entry_pos", got.entry_pos, want.entry_pos);
                if (got.entry_size !== want.entry_size)
                    report_mismatch("entry_size", got.entry_size, want.entry_size);
                if (got.front_pad !== want.front_pad)
                    report_mismatch("front_pad", got.front_pad, want.front_pad);
                if (got.back_pad !== want.back_pad)
                    report_mismatch("back_pad", got.back_pad, want.back_pad);
                if (got.half_crossed !== want.half_crossed)
                    report_mismatch("half_crossed", got.half_crossed, want.half_crossed);
                if (got.header_dirty !== want.header_dirty)
                    report_mismatch("header_dirty", got.header_dirty, want.header_dirty);
                if (got.ring_mode !== want.ring_mode)
                    report_mismatch("ring_mode", got.ring_mode, want.ring_mode);
                if (got.start_pos !== want.start_pos)
                    report_mismatch("start_pos", got.start_pos, want.start_pos);
                if (got.dropped !== want.dropped)
                    report_mismatch("dropped", got.dropped, want.dropped);
            end
            result_count++;
        end
    end

    // Main sequence
    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_APPEND;
        req_ch.seq         = '0;
        req_ch.payload_len = '0;
        req_ch.data_align  = '0;
        cfg_wr_en          = 1'b0;
        cfg_index          = CFG_RING_SIZE;
        cfg_wdata          = '0;
        hold_armed         = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        mismatch_count     = 0;
        result_count       = 0;

        // Reset values of the mirror
        ring_end      = 64'd1048576;
        gran_log2     = 5'd4;
        stall_mode    = 1'b0;
        wr_pos        = 64'(HEADER_REGION);
        live_start    = 64'(HEADER_REGION);
        fill_state    = MODE_NOT_FULL;
        committed_seq = '0;
        fresh_seq     = 64'd103;

        // Directed: idle items after reset, extremes, full/wait cycle, commits
        add_row(ACT_START, 64'd0, 32'd0, 13'd0, 1'b1,
                typed_result(ST_IGNORED, 0, 0, 0, 0, 0, 0, MODE_NOT_FULL, 4096, 0));
        add_row(ACT_NONE, SEQ_ALL_ONES, 32'hFFFF_FFFF, NO_ALIGN, 1'b1,
                typed_result(ST_IGNORED, 0, 0, 0, 0, 0, 0, MODE_NOT_FULL, 4096, 0));
        add_row(ACT_COMMIT, 64'd0, 32'd0, 13'd0, 1'b1,
                typed_result(ST_IGNORED, 0, 0, 0, 0, 0, 0, MODE_NOT_FULL, 4096, 0));
        add_row(ACT_APPEND, 64'd1, 32'd0, NO_ALIGN, 1'b1,
                typed_result(ST_APPENDED, 4096, 64, 0, 0, 0, 0, MODE_NOT_FULL, 4096, 0));
        add_row(ACT_APPEND, 64'd2, 32'hFFFF_FFFF, 13'd4095, 1'b1,
                typed_result(ST_REJECTED, 4160, 64'd4294971424, 4063, 2, 0, 0,
                             MODE_FULL, 4096, 0));
        add_row(ACT_APPEND, 64'd3, 32'd0, NO_ALIGN, 1'b1,
                typed_result(ST_REJECTED, 4160, 64, 0, 0, 0, 0, MODE_FULL, 4096, 0));
        add_row(ACT_START, 64'd0, 32'd0, 13'd0, 1'b1,
                typed_result(ST_IGNORED, 0, 0, 0, 0, 0, 0, MODE_WAIT, 4096, 0));
        add_row(ACT_APPEND, 64'd3, 32'd100, 13'd0, 1'b0, '0);
        add_row(ACT_START, 64'd0, 32'd0, 13'd0, 1'b1,
                typed_result(ST_IGNORED, 0, 0, 0, 0, 0, 0, MODE_NOT_FULL, 4096, 0));
        add_row(ACT_APPEND, 64'd3, 32'd100, 13'd0, 1'b0, '0);
        add_row(ACT_APPEND, 64'd4, 32'd4000, 13'd32, 1'b0, '0);
        add_row(ACT_APPEND, 64'd5, 32'd1, 13'h1000, 1'b0, '0);
        add_row(ACT_APPEND, 64'd6, 32'd7, 13'd33, 1'b0, '0);
        add_row(ACT_COMMIT, 64'd2, 32'd0, 13'd0, 1'b0, '0);
        add_row(ACT_COMMIT, 64'd2, 32'd0, 13'd0, 1'b0, '0);
        add_row(ACT_COMMIT, 64'd5, 32'd0, 13'd0, 1'b0, '0);
        add_row(ACT_APPEND, 64'd7, 32'd540000, 13'd4095, 1'b0, '0);
        add_row(ACT_APPEND, 64'd8, 32'd40000, NO_ALIGN, 1'b0, '0);
        add_row(ACT_APPEND, 64'd9, 32'd600000, NO_ALIGN, 1'b0, '0);
        add_row(ACT_START, 64'd0, 32'd0, 13'd0, 1'b0, '0);
        add_row(ACT_START, 64'd0, 32'd0, 13'd0, 1'b0, '0);
        add_row(ACT_COMMIT, 64'd100, 32'd0, 13'd0, 1'b0, '0);
        add_row(ACT_APPEND, 64'd101, 32'd65535, 13'd4095, 1'b0, '0);
        add_row(ACT_APPEND, 64'd102, 32'd0, 13'd1, 1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            drive_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // Random phases: ring, align, stall, sender idle, receiver stall,
        // items, commit share, long hold-off
        run_phase(41'(HEADER_REGION + 20000), 4, 1'b0, 0, 0, 180, 30, 1'b0);
        run_phase(41'(HEADER_REGION + 40000), 16, 1'b1, 51, 0, 170, 30, 1'b0);
        run_phase(41'(HEADER_REGION + 100000), 7, 1'b0, 0, 51, 190, 8, 1'b0);
        run_phase(41'(HEADER_REGION + 30000), 5, 1'b1, 13, 13, 170, 30, 1'b1);
        run_phase(41'h100_0000_0000, 12, 1'b0, 0, 0, 150, 30, 1'b0);
        run_phase(41'd0, 4, 1'b0, 13, 13, 60, 30, 1'b0);

        // Release everything, then one stale commit at the top of the range
        drive_item('{ACT_COMMIT, SEQ_ALL_ONES, 32'd0, 13'd0}, 1'b0, '0);
        drive_item('{ACT_COMMIT, SEQ_ALL_ONES, 32'd0, 13'd0}, 1'b0, '0);
        drain_results();
        repeat (20) @(posedge clk);

        if (pending_results.size() != 0)
            report_mismatch("missing results", pending_results.size(), 0);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
